// ----- rtl/assert_macros.svh -----
// Assertion macros used by the mixer back end; empty when synthesizing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define QMMB_ASSERT(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
	else $error("assertion failed");
`define QMMB_ASSERT_NEVER(lbl, clk, rstn, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
	else $error("forbidden condition seen");
`else
`define QMMB_ASSERT(lbl, clk, rstn, prop)
`define QMMB_ASSERT_NEVER(lbl, clk, rstn, cond)
`endif
`endif

// ----- rtl/qmmb_pkg.sv -----
// Types and constants of the quad motor mixer and balancer.
`default_nettype none
package qmmb_pkg;
	localparam int unsigned SUM_BITS_DEF = 48;
	localparam int unsigned DRIVE_W      = 16;
	localparam int unsigned CFG_ADDR_W   = 4;
	localparam int unsigned CFG_DATA_W   = 16;
	localparam int unsigned QUEUE_DEPTH  = 2;
	// Scaled operand is 4 * drive, so the quotient never exceeds 18 bits.
	localparam int unsigned QBITS        = DRIVE_W + 2;

	localparam logic [CFG_ADDR_W-1:0] CFG_X_LAYOUT       = 4'd0;
	localparam logic [CFG_ADDR_W-1:0] CFG_MANUAL_ENABLE  = 4'd1;
	localparam logic [CFG_ADDR_W-1:0] CFG_MANUAL_MOTOR1  = 4'd2;
	localparam logic [CFG_ADDR_W-1:0] CFG_MANUAL_MOTOR2  = 4'd3;
	localparam logic [CFG_ADDR_W-1:0] CFG_MANUAL_MOTOR3  = 4'd4;
	localparam logic [CFG_ADDR_W-1:0] CFG_MANUAL_MOTOR4  = 4'd5;
	localparam logic [CFG_ADDR_W-1:0] CFG_AVERAGE_ENABLE = 4'd6;
	localparam logic [CFG_ADDR_W-1:0] CFG_FF_ENABLE      = 4'd7;

	typedef struct packed {
		logic [15:0]        thrust_cmd;
		logic signed [15:0] roll_cmd;
		logic signed [15:0] pitch_cmd;
		logic signed [15:0] yaw_cmd;
	} cmd_t;

	typedef struct packed {
		logic [15:0] motor1_drive;
		logic [15:0] motor2_drive;
		logic [15:0] motor3_drive;
		logic [15:0] motor4_drive;
	} drive_t;

	typedef enum logic {
		JOB_PASS  = 1'b0,
		JOB_SCALE = 1'b1
	} job_kind_t;

	typedef struct packed {
		job_kind_t                    kind;
		logic [3:0][DRIVE_W-1:0]      m;
	} job_t;

	typedef enum logic [1:0] {
		ST_IDLE  = 2'd0,
		ST_TOTAL = 2'd1,
		ST_DIV   = 2'd2,
		ST_DONE  = 2'd3
	} back_state_t;
endpackage
`default_nettype wire

// ----- rtl/quad_motor_mixer_balancer_unit.sv -----
// Top level of the quad motor mixer and balancer.
// Usage:
// A command transaction (thrust, roll, pitch, yaw) enters on in_valid/in_ready
// and produces exactly one drive transaction of four motor values on
// out_valid/out_ready. The front end mixes the command in X or plus layout,
// clamps each motor to 0..65535 and, with averaging on, adds the clamped
// values into four saturating per-motor sums. A two-entry queue hands jobs
// to the back end. Pass-through and manual jobs go from the queue register
// straight into the output register, and while the receiver takes every
// result and no feed-forward job is ahead they sustain one transaction per cycle.
// Feed-forward jobs run four divider lanes in parallel, one quotient bit per
// cycle; the back end takes the job, forms the total, runs 18 divider steps
// and loads the output register, and takes no new job until that is done.
// Configuration writes on cfg_we/cfg_addr/cfg_data take effect at once; the
// user must make them only while no transaction is in flight, which the block
// does not enforce. Reset clears the control and configuration registers
// and the per-motor sums, but not the data registers. When the receiver
// stalls, the result holds in the output register, the back end waits and
// the queue fills; in_ready drops once the queue is full.
`default_nettype none
module quad_motor_mixer_balancer_unit #(
	parameter int unsigned SUM_BITS = qmmb_pkg::SUM_BITS_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_we,
	input  wire logic [qmmb_pkg::CFG_ADDR_W-1:0] cfg_addr,
	input  wire logic [qmmb_pkg::CFG_DATA_W-1:0] cfg_data,
	input  wire logic                            in_valid,
	output logic                                 in_ready,
	input  qmmb_pkg::cmd_t                       in_data,
	output logic                                 out_valid,
	input  wire logic                            out_ready,
	output qmmb_pkg::drive_t                     out_data
);
	import qmmb_pkg::*;

	logic push, push_ready, pop, pop_valid;
	job_t push_job, pop_job;
	logic [3:0][SUM_BITS-1:0] sums;

	// Front end owns configuration and the balance sums.
	qmmb_front #(.SUM_BITS(SUM_BITS)) u_front (
		.clk, .arst_n, .cfg_we, .cfg_addr, .cfg_data,
		.in_valid, .in_ready, .in_data,
		.push, .push_job, .push_ready, .sums
	);

	// Short queue so the front keeps taking commands while the back scales.
	qmmb_queue u_queue (
		.clk, .arst_n, .push, .push_job, .push_ready,
		.pop, .pop_job, .pop_valid
	);

	// Back end reads the sums; they do not move while scaling jobs are
	// pending because scaling only happens with averaging off.
	qmmb_back #(.SUM_BITS(SUM_BITS)) u_back (
		.clk, .arst_n, .job_valid(pop_valid), .job(pop_job), .pop,
		.sums, .out_valid, .out_ready, .out_data
	);
endmodule
`default_nettype wire

// ----- rtl/qmmb_queue.sv -----
// Two-entry job queue between the mixer front and the scaling back end.
`default_nettype none
module qmmb_queue (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         push,
	input  qmmb_pkg::job_t    push_job,
	output logic              push_ready,
	input  wire logic         pop,
	output qmmb_pkg::job_t    pop_job,
	output logic              pop_valid
);
	import qmmb_pkg::*;

	job_t       mem_q [QUEUE_DEPTH];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign push_ready = (count_q != 2'(QUEUE_DEPTH));
	assign pop_valid  = (count_q != 2'd0);
	assign pop_job    = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push && push_ready) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push && push_ready) wr_ptr_q <= ~wr_ptr_q;
			if (pop && pop_valid) rd_ptr_q <= ~rd_ptr_q;
			count_q <= count_q + 2'(push && push_ready) - 2'(pop && pop_valid);
		end
	end
endmodule
`default_nettype wire

// ----- rtl/qmmb_front.sv -----
// Command front end: configuration registers, mixing, clamping and balance sums.
`default_nettype none
module qmmb_front #(
	parameter int unsigned SUM_BITS = qmmb_pkg::SUM_BITS_DEF
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  cfg_we,
	input  wire logic [qmmb_pkg::CFG_ADDR_W-1:0]       cfg_addr,
	input  wire logic [qmmb_pkg::CFG_DATA_W-1:0]       cfg_data,
	input  wire logic                                  in_valid,
	output logic                                       in_ready,
	input  qmmb_pkg::cmd_t                             in_data,
	output logic                                       push,
	output qmmb_pkg::job_t                             push_job,
	input  wire logic                                  push_ready,
	output logic [3:0][SUM_BITS-1:0]                   sums
);
	import qmmb_pkg::*;

	logic                    x_layout_q;
	logic                    manual_q;
	logic                    average_q;
	logic                    ff_q;
	logic [3:0][DRIVE_W-1:0] manual_motor_q;
	logic [3:0][SUM_BITS-1:0] sums_q;

	logic signed [18:0] t_s, r_s, p_s, y_s;
	logic signed [18:0] mix [4];
	logic [3:0][DRIVE_W-1:0] m_c;
	logic [SUM_BITS:0] sum_ext [4];
	logic accept;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_layout_q     <= 1'b0;
			manual_q       <= 1'b0;
			average_q      <= 1'b0;
			ff_q           <= 1'b0;
			manual_motor_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				CFG_X_LAYOUT:       x_layout_q        <= cfg_data[0];
				CFG_MANUAL_ENABLE:  manual_q          <= cfg_data[0];
				CFG_MANUAL_MOTOR1:  manual_motor_q[0] <= cfg_data;
				CFG_MANUAL_MOTOR2:  manual_motor_q[1] <= cfg_data;
				CFG_MANUAL_MOTOR3:  manual_motor_q[2] <= cfg_data;
				CFG_MANUAL_MOTOR4:  manual_motor_q[3] <= cfg_data;
				CFG_AVERAGE_ENABLE: average_q         <= cfg_data[0];
				CFG_FF_ENABLE:      ff_q              <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		t_s = signed'({3'b000, in_data.thrust_cmd});
		r_s = signed'({{3{in_data.roll_cmd[15]}}, in_data.roll_cmd});
		p_s = signed'({{3{in_data.pitch_cmd[15]}}, in_data.pitch_cmd});
		y_s = signed'({{3{in_data.yaw_cmd[15]}}, in_data.yaw_cmd});
		if (x_layout_q) begin
			mix[0] = t_s - r_s + p_s + y_s;
			mix[1] = t_s - r_s - p_s - y_s;
			mix[2] = t_s + r_s - p_s + y_s;
			mix[3] = t_s + r_s + p_s - y_s;
		end else begin
			mix[0] = t_s + p_s + y_s;
			mix[1] = t_s - r_s - y_s;
			mix[2] = t_s - p_s + y_s;
			mix[3] = t_s + r_s - y_s;
		end
		for (int i = 0; i < 4; i++) begin
			if (mix[i] < 0) m_c[i] = '0;
			else if (mix[i] > 19'sd65535) m_c[i] = '1;
			else m_c[i] = mix[i][DRIVE_W-1:0];
			sum_ext[i] = {1'b0, sums_q[i]} + (SUM_BITS+1)'(m_c[i]);
		end
	end

	assign in_ready = push_ready;
	assign accept   = in_valid && in_ready;
	assign push     = accept;
	assign push_job.kind = (!manual_q && !average_q && ff_q) ? JOB_SCALE : JOB_PASS;
	assign push_job.m    = manual_q ? manual_motor_q : m_c;
	assign sums          = sums_q;

	// Sums accumulate under manual override too; they saturate at all ones.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sums_q <= '0;
		end else if (accept && average_q) begin
			for (int i = 0; i < 4; i++) begin
				sums_q[i] <= sum_ext[i][SUM_BITS] ? '1 : sum_ext[i][SUM_BITS-1:0];
			end
		end
	end
endmodule
`default_nettype wire

// ----- rtl/qmmb_back.sv -----
// Back end: feed-forward scaling with four radix-2 divider lanes, output register.
`default_nettype none
`include "assert_macros.svh"
module qmmb_back #(
	parameter int unsigned SUM_BITS = qmmb_pkg::SUM_BITS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  job_valid,
	input  qmmb_pkg::job_t             job,
	output logic                       pop,
	input  wire logic [3:0][SUM_BITS-1:0] sums,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output qmmb_pkg::drive_t           out_data
);
	import qmmb_pkg::*;

	localparam int unsigned TW = SUM_BITS + 2;
	localparam int unsigned XW = TW + 2;
	localparam int unsigned CW = $clog2(QBITS);

	back_state_t st_q, st_d;
	job_t        job_q;
	logic [TW-1:0] total_q;
	logic [TW-1:0] rem_q [4];
	logic [QBITS-1:0] quo_q [4];
	logic [CW-1:0] cnt_q;
	logic out_valid_q;
	drive_t out_q;

	logic out_free, last_step, load_pass, load_done;
	logic [CW-1:0] bit_idx;
	logic [XW-1:0] x_c [4];
	logic [XW-1:0] t1_c, t2_c;
	logic [TW-1:0] rem_d [4];
	logic [QBITS-1:0] quo_d [4];
	logic [3:0][DRIVE_W-1:0] res_c;
	logic [QBITS-1:0] f_c [4];

	assign out_free  = !out_valid_q || out_ready;
	assign last_step = (cnt_q == CW'(QBITS - 1));
	assign bit_idx   = CW'(QBITS - 1) - cnt_q;

	always_comb begin
		st_d = st_q;
		unique case (st_q)
			ST_IDLE:  if (job_valid && out_free && job.kind == JOB_SCALE) st_d = ST_TOTAL;
			ST_TOTAL: st_d = ST_DIV;
			ST_DIV:   if (last_step) st_d = ST_DONE;
			ST_DONE:  if (out_free) st_d = ST_IDLE;
			default:  st_d = ST_IDLE;
		endcase
	end

	always_comb begin
		pop       = (st_q == ST_IDLE) && job_valid && out_free;
		load_pass = pop && (job.kind == JOB_PASS);
		load_done = (st_q == ST_DONE) && out_free;
	end

	// One quotient bit per cycle per lane; the partial remainder stays below
	// the total, so each step needs at most two subtractions of it.
	always_comb begin
		t1_c = XW'(total_q);
		t2_c = XW'({total_q, 1'b0});
		for (int i = 0; i < 4; i++) begin
			f_c[i] = {job_q.m[i], 2'b00};
			x_c[i] = {1'b0, rem_q[i], 1'b0} +
				(f_c[i][bit_idx] ? XW'(sums[i]) : '0);
			if (x_c[i] >= t2_c) begin
				rem_d[i] = TW'(x_c[i] - t2_c);
				quo_d[i] = {quo_q[i][QBITS-2:0], 1'b0} + QBITS'(2);
			end else if (x_c[i] >= t1_c) begin
				rem_d[i] = TW'(x_c[i] - t1_c);
				quo_d[i] = {quo_q[i][QBITS-2:0], 1'b1};
			end else begin
				rem_d[i] = x_c[i][TW-1:0];
				quo_d[i] = {quo_q[i][QBITS-2:0], 1'b0};
			end
			if (total_q == '0) res_c[i] = job_q.m[i];
			else if (quo_q[i][QBITS-1:DRIVE_W] != '0) res_c[i] = '1;
			else res_c[i] = quo_q[i][DRIVE_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (pop) job_q <= job;
		if (st_q == ST_TOTAL) begin
			total_q <= TW'(sums[0]) + TW'(sums[1]) + TW'(sums[2]) + TW'(sums[3]);
			for (int i = 0; i < 4; i++) begin
				rem_q[i] <= '0;
				quo_q[i] <= '0;
			end
		end else if (st_q == ST_DIV) begin
			for (int i = 0; i < 4; i++) begin
				rem_q[i] <= rem_d[i];
				quo_q[i] <= quo_d[i];
			end
		end
		// Motor 1 sits in the most significant field of the drive struct.
		if (load_pass) begin
			out_q <= {job.m[0], job.m[1], job.m[2], job.m[3]};
		end else if (load_done) begin
			out_q <= {res_c[0], res_c[1], res_c[2], res_c[3]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			st_q <= st_d;
			if (st_q == ST_DIV) cnt_q <= cnt_q + CW'(1);
			else cnt_q <= '0;
			if (load_pass || load_done) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	`QMMB_ASSERT(a_rem_below_total, clk, arst_n, (st_q == ST_DIV && total_q != '0) |-> (rem_q[0] < total_q && rem_q[3] < total_q))
	`QMMB_ASSERT(a_div_ends_in_done, clk, arst_n, (st_q == ST_DIV && last_step) |=> (st_q == ST_DONE))
	`QMMB_ASSERT_NEVER(a_pop_only_idle, clk, arst_n, pop && st_q != ST_IDLE)
endmodule
`default_nettype wire
